### hdl/tpg_pkg.sv
// Shared types and codes for the thermal profile governor.
`timescale 1ns / 1ps

package tpg_pkg;

    typedef enum logic [1:0] {
        PROF_SAVE = 2'd0,
        PROF_BAL  = 2'd1,
        PROF_LITE = 2'd2,
        PROF_PERF = 2'd3
    } profile_t;

    typedef enum logic [2:0] {
        TC_UNSUP  = 3'd0,
        TC_NODATA = 3'd1,
        TC_COOL   = 3'd2,
        TC_BAND   = 3'd3,
        TC_PRESS  = 3'd4,
        TC_EMERG  = 3'd5
    } tclass_t;

    typedef enum logic [4:0] {
        R_STARTUP  = 5'd0,
        R_NOTRANS  = 5'd1,
        R_SHUTDOWN = 5'd2,
        R_EMERG    = 5'd3,
        R_PRESS    = 5'd4,
        R_RECOV    = 5'd5,
        R_STALE    = 5'd6,
        R_OFFLINE  = 5'd7,
        R_RESTORED = 5'd8,
        R_BATT     = 5'd9,
        R_SCREEN   = 5'd10,
        R_SSTART   = 5'd11,
        R_SEND     = 5'd12,
        R_CHARGE   = 5'd13,
        R_USER     = 5'd14,
        R_CAPLIM   = 5'd15,
        R_AUDIO    = 5'd16
    } reason_t;

    typedef enum logic [3:0] {
        P_SHUTDOWN = 4'd0,
        P_EMERG    = 4'd1,
        P_TELEM    = 4'd2,
        P_BATT     = 4'd3,
        P_SCREEN   = 4'd4,
        P_SESSION  = 4'd5,
        P_CONFIG   = 4'd6,
        P_CHARGE   = 4'd7,
        P_AUDIO    = 4'd8,
        P_NONCRIT  = 4'd9
    } prio_t;

    typedef enum logic [1:0] {
        H_HEALTHY = 2'd0,
        H_STALE   = 2'd1,
        H_OFFLINE = 2'd2,
        H_UNKNOWN = 2'd3
    } health_t;

    typedef enum logic [2:0] {
        CFG_EMERG_HEADROOM = 3'd0,
        CFG_LITE_ENTER     = 3'd1,
        CFG_LITE_EXIT      = 3'd2,
        CFG_EMERG_LEVEL    = 3'd3,
        CFG_PRESS_LEVEL    = 3'd4,
        CFG_RECOVERY_HOLD  = 3'd5,
        CFG_ENFORCE_LITE   = 3'd6,
        CFG_THERMAL_SUPP   = 3'd7
    } cfg_idx_t;

    localparam int CFG_DATA_W = 32;

    typedef struct packed {
        logic [15:0] emergency_headroom;
        logic [15:0] lite_enter_headroom;
        logic [15:0] lite_exit_headroom;
        logic [2:0]  emergency_status_level;
        logic [2:0]  pressure_status_level;
        logic [31:0] recovery_hold;
        logic        enforce_lite;
        logic        thermal_present;
    } cfg_t;

    typedef struct packed {
        logic [31:0] now_time;
        logic        shutdown_req;
        logic        thermal_valid;
        logic [15:0] headroom;
        logic [2:0]  thermal_status;
        logic [1:0]  health;
        logic        saver_mode;
        logic        screen_on;
        logic        session_live;
        logic        session_forces_lite;
        logic        charging;
        logic        audio_playing;
    } evt_t;

    typedef struct packed {
        logic [1:0] profile;
        logic [4:0] reason_code;
        logic [3:0] priority_code;
        logic       transition_required;
        logic       recovery_ok;
        logic       safety_flag;
        logic       thermal_unsupported_flag;
        logic       stale_lock;
        logic       restore_wait;
        logic       audio_held;
    } dec_t;

    // Classified event as it waits between front and back.
    typedef struct packed {
        evt_t    evt;
        tclass_t tc;
    } work_t;

endpackage

### hdl/tpg_if.sv
// Valid/ready channel interfaces for evaluation events and decisions.
`timescale 1ns / 1ps

interface tpg_evt_if;
    logic           valid;
    logic           ready;
    tpg_pkg::evt_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tpg_dec_if;
    logic           valid;
    logic           ready;
    tpg_pkg::dec_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/tpg_front.sv
// Front end: accept events and classify the thermal reading.
`timescale 1ns / 1ps

module tpg_front (
    input  logic           clk,
    input  logic           rst_n,
    input  tpg_pkg::cfg_t  cfg,
    tpg_evt_if.sink        evt,
    output logic           push,
    output tpg_pkg::work_t push_data,
    input  logic           push_ready
);
    import tpg_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    work_t   work_reg;
    tclass_t tc;
    logic    accept;

    always_comb
    begin
        if (!cfg.thermal_present)
            tc = TC_UNSUP;
        else if (!evt.data.thermal_valid)
            tc = TC_NODATA;
        else if (evt.data.headroom >= cfg.emergency_headroom ||
                 evt.data.thermal_status >= cfg.emergency_status_level)
            tc = TC_EMERG;
        else if (evt.data.headroom >= cfg.lite_enter_headroom ||
                 evt.data.thermal_status >= cfg.pressure_status_level)
            tc = TC_PRESS;
        else if (evt.data.headroom <= cfg.lite_exit_headroom)
            tc = TC_COOL;
        else
            tc = TC_BAND;
    end

    assign evt.ready = !valid_reg || push_ready;
    assign accept    = evt.valid && evt.ready;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (push_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            work_reg.evt <= evt.data;
            work_reg.tc  <= tc;
        end
    end

    assign push      = valid_reg;
    assign push_data = work_reg;

endmodule

### hdl/tpg_queue.sv
// Short queue of classified events between front and back.
`timescale 1ns / 1ps

module tpg_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tpg_pkg::work_t push_data,
    output logic           push_ready,
    output logic           pop_valid,
    output tpg_pkg::work_t pop_data,
    input  logic           pop
);
    import tpg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    work_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

endmodule

### hdl/tpg_back.sv
// Back end: priority ladder, guards, governor state and result register.
`timescale 1ns / 1ps

module tpg_back (
    input  logic           clk,
    input  logic           rst_n,
    input  tpg_pkg::cfg_t  cfg,
    input  logic           pop_valid,
    input  tpg_pkg::work_t pop_data,
    output logic           pop,
    tpg_dec_if.source      dec
);
    import tpg_pkg::*;

    logic [1:0]  cur_prof_reg;
    logic [31:0] last_switch_reg;
    logic [1:0]  prev_health_reg;
    logic        prev_sess_reg;
    logic        prev_chg_reg;
    logic        out_valid_reg, out_valid_next;
    dec_t        out_reg;

    evt_t        e;
    tclass_t     tc;
    logic [1:0]  cand;
    reason_t     reason;
    prio_t       prio;
    logic        safety, recov, locked, settling, aguard;
    logic [31:0] new_switch;
    logic [31:0] elapsed;
    logic        fresh;
    logic        promote;
    logic        load;
    dec_t        res;

    assign e       = pop_data.evt;
    assign tc      = pop_data.tc;
    assign elapsed = e.now_time - last_switch_reg;
    assign fresh   = !prev_sess_reg;

    always_comb
    begin
        cand       = cur_prof_reg;
        reason     = R_NOTRANS;
        prio       = P_NONCRIT;
        safety     = 1'b0;
        recov      = 1'b0;
        locked     = 1'b0;
        settling   = 1'b0;
        aguard     = 1'b0;
        new_switch = last_switch_reg;

        if (e.shutdown_req)
        begin
            cand = PROF_BAL; reason = R_SHUTDOWN; prio = P_SHUTDOWN; safety = 1'b1;
        end
        else if (tc == TC_EMERG)
        begin
            cand = PROF_BAL; reason = R_EMERG; prio = P_EMERG; safety = 1'b1;
            new_switch = e.now_time;
        end
        else if (e.health == H_OFFLINE)
        begin
            cand = PROF_BAL; reason = R_OFFLINE; prio = P_TELEM; safety = 1'b1;
        end
        else if (e.saver_mode)
        begin
            cand = PROF_SAVE; reason = R_BATT; prio = P_BATT; safety = 1'b1;
        end
        else if (!e.screen_on)
        begin
            cand = PROF_BAL; reason = R_SCREEN; prio = P_SCREEN; safety = 1'b1;
        end
        else if (e.session_live)
        begin
            prio = P_SESSION;
            if (e.session_forces_lite || cfg.enforce_lite)
            begin
                cand   = PROF_LITE;
                reason = fresh ? R_SSTART : R_CAPLIM;
            end
            else if (tc == TC_PRESS)
            begin
                cand = PROF_LITE;
                if (cur_prof_reg != PROF_LITE)
                begin
                    reason = R_PRESS; safety = 1'b1; new_switch = e.now_time;
                end
            end
            else if (tc == TC_COOL && cur_prof_reg == PROF_LITE)
            begin
                recov = (elapsed >= cfg.recovery_hold);
                if (recov)
                begin
                    cand = PROF_PERF; reason = R_RECOV; new_switch = e.now_time;
                end
                else
                    cand = PROF_LITE;
            end
            else if ((tc == TC_BAND || tc == TC_NODATA) && cur_prof_reg == PROF_LITE)
                cand = PROF_LITE;
            else
            begin
                cand   = PROF_PERF;
                reason = fresh ? R_SSTART : R_NOTRANS;
            end
        end
        else
        begin
            prio = P_CONFIG;
            cand = PROF_BAL;
            if (prev_sess_reg)
                reason = R_SEND;
            else if (prev_chg_reg != e.charging)
            begin
                reason = R_CHARGE; prio = P_CHARGE;
            end
            else
                reason = (cur_prof_reg == PROF_BAL) ? R_NOTRANS : R_USER;
        end

        // Promotion guards; a switch time already taken stays taken.
        promote = (cand > cur_prof_reg);
        if (promote && e.health == H_STALE)
        begin
            cand = cur_prof_reg; reason = R_STALE; prio = P_TELEM;
            safety = 1'b1; locked = 1'b1;
        end
        else if (promote && prev_health_reg != H_HEALTHY && e.health == H_HEALTHY)
        begin
            cand = cur_prof_reg; reason = R_RESTORED; prio = P_TELEM;
            safety = 1'b1; settling = 1'b1;
        end

        if (!safety && e.audio_playing && reason == R_RECOV && cand > cur_prof_reg)
        begin
            cand = cur_prof_reg; reason = R_AUDIO; prio = P_AUDIO;
            aguard = 1'b1; recov = 1'b0;
        end

        res.profile                  = cand;
        res.reason_code              = reason;
        res.priority_code            = prio;
        res.transition_required      = (cand != cur_prof_reg);
        res.recovery_ok              = recov;
        res.safety_flag              = safety;
        res.thermal_unsupported_flag = (tc == TC_UNSUP);
        res.stale_lock               = locked;
        res.restore_wait             = settling;
        res.audio_held               = aguard;
    end

    assign load = pop_valid && (!out_valid_reg || dec.ready);
    assign pop  = load;

    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (dec.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_prof_reg    <= PROF_BAL;
            last_switch_reg <= '0;
            prev_health_reg <= H_HEALTHY;
            prev_sess_reg   <= 1'b0;
            prev_chg_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                cur_prof_reg    <= cand;
                last_switch_reg <= new_switch;
                prev_health_reg <= e.health;
                prev_sess_reg   <= e.session_live;
                prev_chg_reg    <= e.charging;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= res;
    end

    assign dec.valid = out_valid_reg;
    assign dec.data  = out_reg;

    a_state_follows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (cur_prof_reg == out_reg.profile))
        else $error("current profile differs from the word just loaded");

    a_guard_excl: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> $onehot0({locked, settling, aguard}))
        else $error("more than one promotion guard fired");

    a_audio_nosafety: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !(aguard && (safety || recov)))
        else $error("audio hold with safety or recovery set");

endmodule

### hdl/thermal_profile_governor.sv
// Top level of the thermal profile governor: config registers and the pipeline.
`timescale 1ns / 1ps

// Thermal profile governor. Each evaluation-event word on evt yields exactly one
// decision word on dec, in order. The block sustains one word per clock: a new
// event is taken every cycle while decisions drain. The decision passes through
// the front classify register, one queue slot and the result register before it
// is offered on dec. The rate is set by the back end, whose current-profile and
// switch-time registers close the decision loop. The front classifies headroom
// and status against the thresholds; a short queue decouples it from the back,
// so a stall on dec backs up through the queue before evt loses ready.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; write
// them only while no event is in flight.
module thermal_profile_governor #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [2:0]                      cfg_index,
    input  logic [tpg_pkg::CFG_DATA_W-1:0]  cfg_data,
    tpg_evt_if.sink                         evt,
    tpg_dec_if.source                       dec
);
    import tpg_pkg::*;

    cfg_t  cfg_reg;
    logic  push, push_ready;
    work_t push_data;
    logic  pop_valid, pop;
    work_t pop_data;

    // Hold the configuration registers; index out of use is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.emergency_headroom     <= 16'd4096;
            cfg_reg.lite_enter_headroom    <= 16'd3686;
            cfg_reg.lite_exit_headroom     <= 16'd3072;
            cfg_reg.emergency_status_level <= 3'd5;
            cfg_reg.pressure_status_level  <= 3'd3;
            cfg_reg.recovery_hold          <= 32'd30000;
            cfg_reg.enforce_lite           <= 1'b0;
            cfg_reg.thermal_present        <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_EMERG_HEADROOM: cfg_reg.emergency_headroom     <= cfg_data[15:0];
                CFG_LITE_ENTER:     cfg_reg.lite_enter_headroom    <= cfg_data[15:0];
                CFG_LITE_EXIT:      cfg_reg.lite_exit_headroom     <= cfg_data[15:0];
                CFG_EMERG_LEVEL:    cfg_reg.emergency_status_level <= cfg_data[2:0];
                CFG_PRESS_LEVEL:    cfg_reg.pressure_status_level  <= cfg_data[2:0];
                CFG_RECOVERY_HOLD:  cfg_reg.recovery_hold          <= cfg_data[31:0];
                CFG_ENFORCE_LITE:   cfg_reg.enforce_lite           <= cfg_data[0];
                CFG_THERMAL_SUPP:   cfg_reg.thermal_present        <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Front: accept and classify the thermal reading.
    tpg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .evt        (evt),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    // Queue: absorb back-end stalls.
    tpg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop        (pop)
    );

    // Back: ladder, guards, state update and result register.
    tpg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop       (pop),
        .dec       (dec)
    );

endmodule
